// ===== rtl/mbcv_pkg.sv =====
// Package for the birthday collision verify unit: payload structs, status codes,
// controller states, SHA-512 constants and round functions. No dependencies.
package mbcv_pkg;

  localparam int unsigned BirthdaysPerDigest = 8;
  localparam logic [31:0] ResetMaxNonce = 32'd67108864;
  localparam logic [6:0] ResetSearchBits = 7'd50;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegMaxNonce = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSearchBits = 1'b1;

  typedef struct packed {
    logic [63:0] head_word_0;
    logic [63:0] head_word_1;
    logic [63:0] head_word_2;
    logic [63:0] head_word_3;
    logic [31:0] nonce_first;
    logic [31:0] nonce_second;
  } in_item_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0, ST_EQUAL = 2'd1, ST_OVER = 2'd2, ST_DIFFER = 2'd3
  } status_t;

  typedef struct packed {
    logic       pair_valid;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_FINAL, S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // take input item
    logic load;      // load message block and state for hash sel
    logic sel;       // 0 first nonce, 1 second nonce
    logic round;     // run one round
    logic finish;    // add start values, extract birthday for sel
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    last_round;
    status_t early;
    logic    early_hit;
    logic    same;
  } dp_stat_t;

  typedef logic [63:0] k_tab_t [80];
  localparam k_tab_t RoundK = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef logic [63:0] h_tab_t [8];
  localparam h_tab_t StartH = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bswap(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 8; i++) y[8*i +: 8] = x[8*(7-i) +: 8];
    bswap = y;
  endfunction

endpackage

// ===== rtl/mbcv_ctrl.sv =====
// Controller state machine for the birthday collision verify unit.
// Depends on mbcv_pkg.
module mbcv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mbcv_pkg::dp_stat_t stat,
  output mbcv_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              done,
  output logic              busy_next
);
  import mbcv_pkg::*;

  ctl_state_t state, state_next;
  logic sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          sel_next    = 1'b0;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.early_hit) begin
          state_next = S_DONE;
        end else begin
          cmd.load   = 1'b1;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        if (sel) begin
          state_next = S_DONE;
        end else begin
          sel_next   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign busy_next = (state_next != S_IDLE);
endmodule

// ===== rtl/mbcv_dp.sv =====
// Datapath: input capture, SHA-512 round engine with rolling schedule,
// birthday extraction and compare. Depends on mbcv_pkg.
module mbcv_dp (
  input  logic               clk,
  input  mbcv_pkg::in_item_t in_item,
  input  logic [31:0]        max_nonce,
  input  logic [6:0]         search_bits,
  input  mbcv_pkg::dp_cmd_t  cmd,
  output mbcv_pkg::dp_stat_t stat,
  output mbcv_pkg::out_item_t res
);
  import mbcv_pkg::*;

  in_item_t     item;
  logic [63:0]  w [16];
  logic [63:0]  v [8];
  logic [6:0]   rnd;
  logic [63:0]  bday0;
  logic [63:0]  bday1;
  logic [31:0]  nonce;
  logic [63:0]  blk [16];
  logic [63:0]  t1, t2, s0, s1, wn;
  logic [63:0]  hsel, word, kept;
  logic [6:0]   keep;

  assign nonce = cmd.sel ? item.nonce_second : item.nonce_first;

  // message block: base nonce LE, header bytes, pad, length 288
  always_comb begin
    logic [7:0] m [128];
    logic [31:0] base;
    base = {nonce[31:3], 3'b000};
    for (int i = 0; i < 128; i++) m[i] = 8'h00;
    for (int i = 0; i < 4; i++) m[i] = base[8*i +: 8];
    for (int i = 0; i < 8; i++) begin
      m[4 + i]  = item.head_word_0[8*i +: 8];
      m[12 + i] = item.head_word_1[8*i +: 8];
      m[20 + i] = item.head_word_2[8*i +: 8];
      m[28 + i] = item.head_word_3[8*i +: 8];
    end
    m[36]  = 8'h80;
    m[126] = 8'h01;
    m[127] = 8'h20;
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++) blk[i][8*(7-j) +: 8] = m[i*8 + j];
  end

  assign s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
  assign s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
  assign wn = w[0] + s0 + w[9] + s1;
  assign t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + w[0];
  assign t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign hsel = v[nonce[2:0]] + StartH[nonce[2:0]];
  assign word = bswap(hsel);
  assign keep = (search_bits > 7'd64) ? 7'd64 : search_bits;
  assign kept = (keep == 7'd0) ? 64'd0 : (word >> (7'd64 - keep));

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) w[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= StartH[i];
      rnd <= '0;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      rnd <= rnd + 7'd1;
    end
    if (cmd.finish) begin
      if (cmd.sel) bday1 <= kept;
      else bday0 <= kept;
    end
  end

  always_comb begin
    stat.last_round = (rnd == 7'd79);
    stat.same       = (bday0 == bday1);
    stat.early_hit  = 1'b1;
    priority if (item.nonce_first == item.nonce_second) stat.early = ST_EQUAL;
    else if (item.nonce_first > max_nonce || item.nonce_second > max_nonce)
      stat.early = ST_OVER;
    else begin
      stat.early     = ST_MATCH;
      stat.early_hit = 1'b0;
    end
  end

  always_comb begin
    status_t s;
    if (stat.early_hit) s = stat.early;
    else if (stat.same) s = ST_MATCH;
    else s = ST_DIFFER;
    res.pair_valid = (s == ST_MATCH);
    res.status     = s;
  end
endmodule

// ===== rtl/momentum_birthday_collision_verify_unit.sv =====
// Top level of the birthday collision verify unit: config registers,
// controller and datapath. Depends on mbcv_pkg, mbcv_ctrl, mbcv_dp.
//
//  channel  | ports                        | transfer when
//  ---------+------------------------------+--------------------------
//  input    | start, busy, in_item         | start && !busy
//  result   | result_strobe, out_item      | result_strobe
//  config   | cfg_we, cfg_index, cfg_data  | cfg_we
//
// When the input is rejected early, the result follows its load state; else it
// comes after two SHA-512 compressions of 80 rounds on one shared round unit,
// plus load, finish and result states. Reset clears the controller and the
// config registers to their defaults. The receiver cannot stall; a result is
// shown for one cycle and busy drops in the cycle after.
module momentum_birthday_collision_verify_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  mbcv_pkg::in_item_t               in_item,
  output logic                             result_strobe,
  output mbcv_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [mbcv_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mbcv_pkg::CfgDataW-1:0]    cfg_data
);
  import mbcv_pkg::*;

  logic [31:0] max_nonce;
  logic [6:0]  search_bits;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  out_item_t   res;
  logic        done;
  logic        busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nonce   <= ResetMaxNonce;
      search_bits <= ResetSearchBits;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegMaxNonce:   max_nonce   <= cfg_data;
        RegSearchBits: search_bits <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  mbcv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(done), .busy_next(busy_next)
  );

  mbcv_dp u_dp (
    .clk(clk), .in_item(in_item), .max_nonce(max_nonce),
    .search_bits(search_bits), .cmd(cmd), .stat(stat), .res(res)
  );

  assign result_strobe = done;
  assign out_item      = res;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy && !busy_next) else $error("result outside busy");
  a_accept_go: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept lost");
  a_valid_status: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (out_item.pair_valid == (out_item.status == ST_MATCH)))
    else $error("pair_valid mismatch");
endmodule
